FILE: design/soi_pkg.sv
// ----------------------------------------------------------------------------
// soi_pkg
// Shared defaults for the segment / obstacle intersection block.
// ----------------------------------------------------------------------------
package soi_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

endpackage

FILE: design/soi_if.sv
// ----------------------------------------------------------------------------
// soi_if
// Request and result channels of the segment / obstacle intersection block.
// ----------------------------------------------------------------------------
interface soi_req_if #(
    parameter int COORD_BITS = soi_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic        [COORD_BITS-2:0] obstacle_radius;
    logic                         is_cylinder;
    logic        [COORD_BITS-1:0] obstacle_height;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               center_x, center_y, center_z, obstacle_radius, is_cylinder,
               obstacle_height,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               center_x, center_y, center_z, obstacle_radius, is_cylinder,
               obstacle_height,
        output ready
    );
endinterface

interface soi_res_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );
    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

FILE: design/soi_front.sv
// ----------------------------------------------------------------------------
// soi_front
// Accept requests, flatten cylinders, form direction and offset vectors,
// the slab cancel flag and the dot products for the projection.
// ----------------------------------------------------------------------------
module soi_front #(
    parameter int COORD_BITS = soi_pkg::COORD_BITS_DEF,
    parameter int MID_W      = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    soi_req_if.sink          req,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [MID_W-1:0] out_data
);
    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int MW  = CW;
    localparam int PW  = 2 * MW;
    localparam int L2W = PW + 2;
    localparam int RW  = CW - 1;
    localparam int HW  = CW + 2;

    typedef struct packed {
        logic [2:0][DW-1:0] d;
        logic [2:0][DW-1:0] w;
        logic [L2W-1:0]     len2;
        logic [L2W-1:0]     pos;
        logic [L2W-1:0]     neg;
        logic [2*RW-1:0]    rad2;
        logic               kill;
    } mid_t;

    logic               en;
    logic               v1_reg;
    logic               v2_reg;
    logic [2:0][DW-1:0] d1_next;
    logic [2:0][DW-1:0] w1_next;
    logic               kill1_next;
    logic [2:0][DW-1:0] d1_reg;
    logic [2:0][DW-1:0] w1_reg;
    logic               kill1_reg;
    logic [RW-1:0]      rad1_reg;
    mid_t               m2_next;
    mid_t               m2_reg;

    assign en        = !v2_reg || out_ready;
    assign req.ready = en;
    assign out_valid = v2_reg;
    assign out_data  = m2_reg;

    always_comb
    begin
        logic signed [DW-1:0] sz;
        logic signed [DW-1:0] ez;
        logic signed [DW-1:0] cz;
        logic signed [HW-1:0] s2;
        logic signed [HW-1:0] e2;
        logic signed [HW-1:0] top2;
        logic signed [HW-1:0] bot2;
        logic signed [HW-1:0] hh;
        sz = req.is_cylinder ? '0 : DW'(req.start_z);
        ez = req.is_cylinder ? '0 : DW'(req.end_z);
        cz = req.is_cylinder ? '0 : DW'(req.center_z);
        d1_next[0] = DW'(req.end_x) - DW'(req.start_x);
        d1_next[1] = DW'(req.end_y) - DW'(req.start_y);
        d1_next[2] = ez - sz;
        w1_next[0] = DW'(req.center_x) - DW'(req.start_x);
        w1_next[1] = DW'(req.center_y) - DW'(req.start_y);
        w1_next[2] = cz - sz;
        s2   = HW'(req.start_z) <<< 1;
        e2   = HW'(req.end_z) <<< 1;
        hh   = $signed({2'b00, req.obstacle_height});
        top2 = (HW'(req.center_z) <<< 1) + hh;
        bot2 = (HW'(req.center_z) <<< 1) - hh;
        kill1_next = req.is_cylinder &&
                     ((s2 > top2 && e2 > top2) || (s2 < bot2 && e2 < bot2));
    end

    always_comb
    begin
        logic signed [DW-1:0] ds;
        logic signed [DW-1:0] ws;
        logic [DW-1:0]        da;
        logic [DW-1:0]        wa;
        logic [MW-1:0]        md;
        logic [MW-1:0]        mw;
        m2_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            ds = $signed(d1_reg[i]);
            ws = $signed(w1_reg[i]);
            da = ds[DW-1] ? DW'(-ds) : DW'(ds);
            wa = ws[DW-1] ? DW'(-ws) : DW'(ws);
            md = da[MW-1:0];
            mw = wa[MW-1:0];
            m2_next.len2 = m2_next.len2 + L2W'(PW'(md) * PW'(md));
            if (ds[DW-1] != ws[DW-1])
            begin
                m2_next.neg = m2_next.neg + L2W'(PW'(md) * PW'(mw));
            end
            else
            begin
                m2_next.pos = m2_next.pos + L2W'(PW'(md) * PW'(mw));
            end
        end
        m2_next.d    = d1_reg;
        m2_next.w    = w1_reg;
        m2_next.rad2 = (2*RW)'(rad1_reg) * (2*RW)'(rad1_reg);
        m2_next.kill = kill1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg    <= d1_next;
            w1_reg    <= w1_next;
            kill1_reg <= kill1_next;
            rad1_reg  <= req.obstacle_radius;
            m2_reg    <= m2_next;
        end
    end
endmodule

FILE: design/soi_queue.sv
// ----------------------------------------------------------------------------
// soi_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module soi_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = soi_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNTW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

FILE: design/soi_back.sv
// ----------------------------------------------------------------------------
// soi_back
// Clamp and divide for t one bit a stage, form the closest point offset,
// square it in partial products and compare against radius squared.
// ----------------------------------------------------------------------------
module soi_back #(
    parameter int COORD_BITS  = soi_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = soi_pkg::T_FRAC_BITS_DEF,
    parameter int MID_W       = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [MID_W-1:0] in_data,
    soi_res_if.source        res
);
    localparam int CW   = COORD_BITS;
    localparam int T    = T_FRAC_BITS;
    localparam int DW   = CW + 1;
    localparam int MW   = CW;
    localparam int PW   = 2 * MW;
    localparam int L2W  = PW + 2;
    localparam int RW   = CW - 1;
    localparam int TW   = T + 1;
    localparam int QW   = CW + T + 3;
    localparam int QM   = QW - 1;
    localparam int QL   = QM / 2;
    localparam int QH   = QM - QL;
    localparam int SQW  = 2 * QM;
    localparam int CMPW = SQW + 2;

    typedef struct packed {
        logic [2:0][DW-1:0] d;
        logic [2:0][DW-1:0] w;
        logic [L2W-1:0]     len2;
        logic [L2W-1:0]     pos;
        logic [L2W-1:0]     neg;
        logic [2*RW-1:0]    rad2;
        logic               kill;
    } mid_t;

    typedef struct packed {
        logic [2:0][DW-1:0] d;
        logic [2:0][DW-1:0] w;
        logic [L2W-1:0]     len2;
        logic [L2W:0]       rem;
        logic [TW-1:0]      t;
        logic               done;
        logic [2*RW-1:0]    rad2;
        logic               kill;
    } bk_t;

    function automatic bk_t dstep(bk_t a);
        bk_t          r;
        logic [L2W:0] r2;
        r  = a;
        r2 = {a.rem[L2W-1:0], 1'b0};
        if (!a.done)
        begin
            if (r2 >= (L2W+1)'(a.len2))
            begin
                r.rem = r2 - (L2W+1)'(a.len2);
                r.t   = {a.t[TW-2:0], 1'b1};
            end
            else
            begin
                r.rem = r2;
                r.t   = {a.t[TW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    mid_t                m_in;
    logic                en;
    bk_t                 init_next;
    bk_t                 b_reg [T+1];
    logic [T:0]          bv_reg;
    logic [2:0][QM-1:0]  q_next;
    logic [2:0][QM-1:0]  q_reg;
    logic [2*RW-1:0]     rad2_q_reg;
    logic                kill_q_reg;
    logic                vq_reg;
    logic [2:0][2*QH-1:0]  hh_reg;
    logic [2:0][QH+QL-1:0] hl_reg;
    logic [2:0][2*QL-1:0]  ll_reg;
    logic [2*RW-1:0]     rad2_p_reg;
    logic                kill_p_reg;
    logic                vp_reg;
    logic [2:0][SQW-1:0] sq_reg;
    logic [2*RW-1:0]     rad2_s_reg;
    logic                kill_s_reg;
    logic                vs_reg;
    logic                hit_next;
    logic                hit_reg;
    logic                vo_reg;

    assign m_in      = in_data;
    assign en        = !vo_reg || res.ready;
    assign in_ready  = en;
    assign res.valid = vo_reg;
    assign res.hit   = hit_reg;

    always_comb
    begin
        logic [L2W-1:0] diff;
        diff             = m_in.pos - m_in.neg;
        init_next        = '0;
        init_next.d      = m_in.d;
        init_next.w      = m_in.w;
        init_next.len2   = m_in.len2;
        init_next.rad2   = m_in.rad2;
        init_next.kill   = m_in.kill;
        if (m_in.len2 == '0 || m_in.neg >= m_in.pos)
        begin
            init_next.done = 1'b1;
        end
        else if (diff >= m_in.len2)
        begin
            init_next.t    = {1'b1, {T{1'b0}}};
            init_next.done = 1'b1;
        end
        else
        begin
            init_next.rem  = {1'b0, diff};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg[0] <= init_next;
        end
    end

    for (genvar k = 1; k <= T; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                b_reg[k] <= dstep(b_reg[k-1]);
            end
        end
    end

    always_comb
    begin
        logic signed [QW-1:0] qv;
        logic signed [QW-1:0] ts;
        logic [QW-1:0]        qa;
        ts = $signed(QW'({1'b0, b_reg[T].t}));
        for (int i = 0; i < 3; i++)
        begin
            qv = QW'($signed(b_reg[T].d[i])) * ts
                 - (QW'($signed(b_reg[T].w[i])) <<< T);
            qa = qv[QW-1] ? QW'(-qv) : QW'(qv);
            q_next[i] = qa[QM-1:0];
        end
    end

    always_comb
    begin
        logic [CMPW-1:0] dist2;
        logic [CMPW-1:0] lim;
        dist2 = CMPW'(sq_reg[0]) + CMPW'(sq_reg[1]) + CMPW'(sq_reg[2]);
        lim   = CMPW'(rad2_s_reg) << (2 * T);
        hit_next = (lim >= dist2) && !kill_s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg      <= q_next;
            rad2_q_reg <= b_reg[T].rad2;
            kill_q_reg <= b_reg[T].kill;
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= (2*QH)'(q_reg[i][QM-1:QL]) * (2*QH)'(q_reg[i][QM-1:QL]);
                hl_reg[i] <= (QH+QL)'(q_reg[i][QM-1:QL]) * (QH+QL)'(q_reg[i][QL-1:0]);
                ll_reg[i] <= (2*QL)'(q_reg[i][QL-1:0]) * (2*QL)'(q_reg[i][QL-1:0]);
                sq_reg[i] <= (SQW'(hh_reg[i]) << (2 * QL))
                             + (SQW'(hl_reg[i]) << (QL + 1))
                             + SQW'(ll_reg[i]);
            end
            rad2_p_reg <= rad2_q_reg;
            kill_p_reg <= kill_q_reg;
            rad2_s_reg <= rad2_p_reg;
            kill_s_reg <= kill_p_reg;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= '0;
            vq_reg <= 1'b0;
            vp_reg <= 1'b0;
            vs_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            bv_reg <= {bv_reg[T-1:0], in_valid};
            vq_reg <= bv_reg[T];
            vp_reg <= vq_reg;
            vs_reg <= vp_reg;
            vo_reg <= vs_reg;
        end
    end
endmodule

FILE: design/segment_obstacle_intersect.sv
// ----------------------------------------------------------------------------
// segment_obstacle_intersect
// Tell whether a path segment touches a sphere or an upright cylinder.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                     handshake
//   req      in   segment endpoints, obstacle center/size     valid/ready
//   res      out  hit                                         valid/ready
//
// One request per cycle sustained while results are taken; t comes from a
// one-bit-per-stage divider.
// Reset clears only the front/back valid bits and queue pointers and count.
// A stalled result halts the back; the queue then fills and halts the front.
// ----------------------------------------------------------------------------
module segment_obstacle_intersect #(
    parameter int COORD_BITS  = soi_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = soi_pkg::T_FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    soi_req_if.sink   req,
    soi_res_if.source res
);
    localparam int DW    = COORD_BITS + 1;
    localparam int L2W   = 2 * COORD_BITS + 2;
    localparam int RW    = COORD_BITS - 1;
    localparam int MID_W = 6 * DW + 3 * L2W + 2 * RW + 1;

    logic             f_valid;
    logic             f_ready;
    logic [MID_W-1:0] f_data;
    logic             q_valid;
    logic             q_ready;
    logic [MID_W-1:0] q_data;

    soi_front #(
        .COORD_BITS (COORD_BITS),
        .MID_W      (MID_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    soi_queue #(
        .WIDTH (MID_W),
        .DEPTH (soi_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    soi_back #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .MID_W       (MID_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .res      (res)
    );

    a_back_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |-> !q_ready)
        else $error("back took a request while the result was stalled");

    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_data))
        else $error("front dropped or changed a stalled request");

    a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> f_valid && !f_ready)
        else $error("front stalled with room in the queue");
endmodule

FILE: bench/soi_checker.sv
// ----------------------------------------------------------------------------
// soi_checker
// Watches the request and result channels, computes the expected hit flag for
// every accepted request and compares it in order with each accepted result.
// ----------------------------------------------------------------------------
module soi_checker (
    input  logic      clk,
    input  logic      rst_n,
    soi_req_if.sink   req,
    soi_res_if.sink   res,
    output int        errors,
    output int        pending
);

    localparam int TF = soi_pkg::T_FRAC_BITS_DEF;

    bit hit_queue[$];
    int err_count = 0;

    function automatic bit compute_hit(
        logic signed [23:0] sx, logic signed [23:0] sy, logic signed [23:0] sz,
        logic signed [23:0] ex, logic signed [23:0] ey, logic signed [23:0] ez,
        logic signed [23:0] cx, logic signed [23:0] cy, logic signed [23:0] cz,
        logic [22:0] rad, logic cyl, logic [23:0] hgt);
        longint s[3], e[3], c[3], d[3], w[3];
        longint t, q, top2, bot2;
        logic signed [127:0] len2, dotp, rem, dist2, lim;
        bit hit;
        s[0] = sx; s[1] = sy; s[2] = cyl ? 0 : longint'(sz);
        e[0] = ex; e[1] = ey; e[2] = cyl ? 0 : longint'(ez);
        c[0] = cx; c[1] = cy; c[2] = cyl ? 0 : longint'(cz);
        len2 = 0;
        dotp = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = e[i] - s[i];
            w[i] = c[i] - s[i];
            len2 += 128'(d[i]) * 128'(d[i]);
            dotp += 128'(d[i]) * 128'(w[i]);
        end
        t = 0;
        if (len2 != 0 && dotp > 0)
        begin
            if (dotp >= len2)
                t = 1 << TF;
            else
            begin
                rem = dotp;
                for (int k = 0; k < TF; k++)
                begin
                    rem = rem <<< 1;
                    t = t * 2;
                    if (rem >= len2)
                    begin
                        rem -= len2;
                        t += 1;
                    end
                end
            end
        end
        dist2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            q = d[i] * t - w[i] * (longint'(1) << TF);
            dist2 += 128'(q) * 128'(q);
        end
        lim = (128'(rad) * 128'(rad)) <<< (2 * TF);
        hit = (lim >= dist2);
        if (hit && cyl)
        begin
            top2 = 2 * longint'(cz) + longint'(hgt);
            bot2 = 2 * longint'(cz) - longint'(hgt);
            if ((2 * longint'(sz) > top2 && 2 * longint'(ez) > top2) ||
                (2 * longint'(sz) < bot2 && 2 * longint'(ez) < bot2))
                hit = 0;
        end
        return hit;
    endfunction

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    assign pending = hit_queue.size();
    assign errors  = err_count;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                hit_queue.push_back(compute_hit(req.start_x, req.start_y, req.start_z,
                    req.end_x, req.end_y, req.end_z, req.center_x, req.center_y,
                    req.center_z, req.obstacle_radius, req.is_cylinder,
                    req.obstacle_height));
            if (res.valid && res.ready)
            begin
                if (hit_queue.size() == 0)
                    report("result with no request waiting");
                else
                begin
                    bit want;
                    want = hit_queue.pop_front();
                    if (res.hit !== want)
                        report($sformatf("hit got %b want %b", res.hit, want));
                end
            end
        end
    end

endmodule

FILE: bench/tb_segment_obstacle_intersect.sv
// ----------------------------------------------------------------------------
// tb_segment_obstacle_intersect
// Drives directed and random segment / obstacle requests with random gaps and
// result stalls; the checker predicts and compares each hit flag.
// ----------------------------------------------------------------------------
module tb_segment_obstacle_intersect;

    localparam int N_RANDOM = 1450;
    localparam int LIMIT    = 400000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   calm;

    soi_req_if req ();
    soi_res_if res ();

    segment_obstacle_intersect u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source)
    );

    soi_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .res     (res.sink),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[segment_obstacle_intersect] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        res.ready <= calm || ($urandom_range(99) >= 18);

    function automatic logic [23:0] rand_coord(input int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(4000)) - 2000);
            2: return ($urandom_range(1)) ? 24'h7fffff : 24'h800000;
            default: return 24'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    task automatic send(
        input logic [23:0] sx, input logic [23:0] sy, input logic [23:0] sz,
        input logic [23:0] ex, input logic [23:0] ey, input logic [23:0] ez,
        input logic [23:0] cx, input logic [23:0] cy, input logic [23:0] cz,
        input logic [22:0] rad, input logic cyl, input logic [23:0] hgt);
        while (!calm && $urandom_range(99) < 18)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.start_x         <= sx;
        req.start_y         <= sy;
        req.start_z         <= sz;
        req.end_x           <= ex;
        req.end_y           <= ey;
        req.end_z           <= ez;
        req.center_x        <= cx;
        req.center_y        <= cy;
        req.center_z        <= cz;
        req.obstacle_radius <= rad;
        req.is_cylinder     <= cyl;
        req.obstacle_height <= hgt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic send_random();
        int m;
        logic [23:0] cx, cy, cz;
        m = $urandom_range(3);
        cx = rand_coord(m);
        cy = rand_coord(m);
        cz = rand_coord(m);
        if (m == 0)
            send(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                 rand_coord(0), rand_coord(0), cx, cy, cz, 23'($urandom),
                 1'($urandom_range(1)), 24'($urandom));
        else
            send(rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m),
                 rand_coord(m), rand_coord(m), cx, cy, cz,
                 23'($urandom_range(m == 2 ? 8388607 : 3000)),
                 1'($urandom_range(1)),
                 24'($urandom_range(m == 2 ? 16777215 : 6000)));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        calm      = 1'b0;
        req.valid = 1'b0;
        {req.start_x, req.start_y, req.start_z, req.end_x, req.end_y, req.end_z,
         req.center_x, req.center_y, req.center_z, req.obstacle_radius,
         req.is_cylinder, req.obstacle_height} = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(0, 0, 0, 0, 0, 0, 10, 0, 0, 10, 0, 0);
        send(0, 0, 0, 0, 0, 0, 10, 0, 0, 9, 0, 0);
        send(0, 0, 0, 1000, 0, 0, -500, 100, 0, 600, 0, 0);
        send(0, 0, 0, 1000, 0, 0, 1500, 100, 0, 600, 0, 0);
        send(0, 0, 0, 1000, 0, 0, 500, 100, 0, 100, 0, 0);
        send(0, 0, 0, 1000, 0, 0, 500, 100, 0, 99, 0, 0);
        send(0, 0, 300, 1000, 0, 300, 500, 0, 0, 50, 1, 600);
        send(0, 0, 301, 1000, 0, 400, 500, 0, 0, 50, 1, 600);
        send(0, 0, -301, 1000, 0, -400, 500, 0, 0, 50, 1, 600);
        send(0, 0, -300, 1000, 0, -400, 500, 0, 0, 50, 1, 600);
        send(0, 0, 301, 1000, 0, 400, 500, 0, 0, 50, 0, 600);
        send(24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff,
             0, 0, 0, 23'h7fffff, 0, 24'hffffff);
        send(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000,
             24'h7fffff, 24'h7fffff, 24'h800000, 0, 1, 24'hffffff);
        send(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
             24'h7fffff, 24'h7fffff, 24'h7fffff, 23'h7fffff, 1, 0);
        send(7, 3, 0, 7, 3, 0, 7, 3, 0, 0, 1, 0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 300)
            begin
                req.valid <= 1'b0;
                while (pending != 0)
                    @(posedge clk);
            end
            calm = (i >= 600 && i < 800);
            send_random();
        end
        req.valid <= 1'b0;
        calm = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[segment_obstacle_intersect] OK");
        else
            $display("[segment_obstacle_intersect] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
design/soi_pkg.sv
design/soi_if.sv
design/soi_front.sv
design/soi_queue.sv
design/soi_back.sv
design/segment_obstacle_intersect.sv
bench/soi_checker.sv
bench/tb_segment_obstacle_intersect.sv
